/* hw/rtl/usbdrf_pkg.sv */
// ---------------------------------------------------------------------------
// usbdrf_pkg
// Register offsets, request codes and alias codes for the USB device
// controller register file.
// ---------------------------------------------------------------------------
package usbdrf_pkg;

  typedef logic [1:0]  req_t;
  typedef logic [1:0]  alias_t;
  typedef logic [11:0] reg_addr_t;

  localparam req_t REQ_READ      = 2'd0;
  localparam req_t REQ_WRITE     = 2'd1;
  localparam req_t REQ_SET_STAT  = 2'd2;
  localparam req_t REQ_SET_BUFF  = 2'd3;

  localparam logic [1:0] TGT_SIE_STATUS  = 2'd0;
  localparam logic [1:0] TGT_BUFF_STATUS = 2'd1;
  localparam logic [1:0] TGT_STALL_NAK   = 2'd2;
  localparam logic [1:0] TGT_SOF         = 2'd3;

  localparam alias_t ALIAS_PLAIN = 2'd0;
  localparam alias_t ALIAS_XOR   = 2'd1;
  localparam alias_t ALIAS_SET   = 2'd2;
  localparam alias_t ALIAS_CLR   = 2'd3;

  localparam reg_addr_t REG_ADDR_ENDP     = 12'h000;
  localparam reg_addr_t REG_MAIN_CTRL     = 12'h040;
  localparam reg_addr_t REG_SOF_WR        = 12'h044;
  localparam reg_addr_t REG_SOF_RD        = 12'h048;
  localparam reg_addr_t REG_SIE_CTRL      = 12'h04C;
  localparam reg_addr_t REG_SIE_STATUS    = 12'h050;
  localparam reg_addr_t REG_BUFF_STATUS   = 12'h058;
  localparam reg_addr_t REG_EP_ABORT_DONE = 12'h064;
  localparam reg_addr_t REG_EP_STALL_ARM  = 12'h068;
  localparam reg_addr_t REG_NAK_POLL      = 12'h06C;
  localparam reg_addr_t REG_EP_STALL_NAK  = 12'h070;
  localparam reg_addr_t REG_MUXING        = 12'h074;
  localparam reg_addr_t REG_PWR           = 12'h078;
  localparam reg_addr_t REG_INTR          = 12'h08C;
  localparam reg_addr_t REG_INTE          = 12'h090;
  localparam reg_addr_t REG_INTF          = 12'h094;
  localparam reg_addr_t REG_INTS          = 12'h098;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

endpackage

/* hw/rtl/usb_device_register_file.sv */
// ---------------------------------------------------------------------------
// usb_device_register_file
// Register file of a USB device controller with plain, XOR, SET and CLR
// aliases, write-1-to-clear status registers and a masked interrupt output.
// ---------------------------------------------------------------------------
// The input channel carries one transaction per item: a bus read, a bus
// write of 1, 2 or 4 bytes, or a status-set event from the serial engine.
// Offset bits 13:12 select the alias, bits 11:0 the register byte offset.
// The output channel returns one result per transaction: the lane-shifted
// read data (zero for writes and events) and the interrupt request as it
// stands after the transaction.
// The register update and the read happen in the accept cycle; the result
// sits in the output register from the next cycle on. A transaction is
// accepted every cycle (throughput 1 per cycle) as long as the output
// register is empty or being drained in the same cycle.
// While the receiver stalls a pending result, in_stall is raised and the
// held result does not change.
// Reset clears every register of the file, the SOF pending flag and the output valid; rdata and irq_line are not reset.
// ---------------------------------------------------------------------------
module usb_device_register_file
  import usbdrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [13:0] offset,
  input  logic [31:0] wdata,
  input  logic [2:0]  byte_count,
  input  logic [1:0]  event_target,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] rdata,
  output logic        irq_line
);

  logic [31:0] address_endpoint, main_control, frame_number, serial_control;
  logic [31:0] serial_status, buffer_status, stall_arm, nak_poll_reg;
  logic [31:0] stall_nak_status, muxing_reg, power_reg, irq_enable, irq_force;
  logic        frame_pending;

  logic [31:0] address_endpoint_next, main_control_next, frame_number_next;
  logic [31:0] serial_control_next, serial_status_next, buffer_status_next;
  logic [31:0] stall_arm_next, nak_poll_reg_next, stall_nak_status_next;
  logic [31:0] muxing_reg_next, power_reg_next, irq_enable_next, irq_force_next;
  logic        frame_pending_next;

  logic        accept;
  alias_t      op;
  reg_addr_t   reg_addr;
  logic [4:0]  shift;
  logic [31:0] mask, lane, peek, rdata_next;
  logic        irq_next;

  function automatic logic [31:0] live_intr(input logic [31:0] ss, input logic [31:0] bs,
                                            input logic [31:0] sn, input logic fp);
    logic [31:0] r;
    r      = '0;
    r[16]  = ss[17];
    r[15]  = ss[11];
    r[14]  = ss[4];
    r[13]  = ss[16];
    r[12]  = ss[19];
    r[11]  = ss[0];
    r[10]  = ss[29];
    r[9]   = ss[24];
    r[8]   = ss[25];
    r[7]   = ss[26];
    r[6]   = ss[27];
    r[5]   = ss[31];
    r[3]   = ss[18];
    r[4]   = |bs;
    r[19]  = |sn;
    r[17]  = fp;
    return r;
  endfunction

  // plain writes merge lanes, or clear written ones for status registers
  function automatic logic [31:0] wr_value(input alias_t a, input logic [31:0] cur,
                                           input logic [31:0] ln, input logic [31:0] msk,
                                           input logic w1c);
    logic [31:0] v;
    v = cur;
    case (a)
      ALIAS_XOR: v = cur ^ ln;
      ALIAS_SET: v = cur | ln;
      ALIAS_CLR: v = cur & ~ln;
      default:   v = w1c ? (cur & ~ln) : ((cur & ~msk) | ln);
    endcase
    return v;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;
  assign op       = offset[13:12];
  assign reg_addr = {offset[11:2], 2'b00};

  always_comb begin
    if (byte_count == 3'd1) begin
      shift = {offset[1:0], 3'b000};
      mask  = 32'h0000_00FF << shift;
    end else if (byte_count == 3'd2) begin
      shift = {offset[1], 4'b0000};
      mask  = 32'h0000_FFFF << shift;
    end else begin
      shift = 5'd0;
      mask  = ALL_ONES;
    end
    lane = (wdata << shift) & mask;
  end

  always_comb begin
    unique case (reg_addr)
      REG_ADDR_ENDP:           peek = address_endpoint;
      REG_MAIN_CTRL:           peek = main_control;
      REG_SOF_WR, REG_SOF_RD:  peek = frame_number;
      REG_SIE_CTRL:            peek = serial_control;
      REG_SIE_STATUS:          peek = serial_status;
      REG_BUFF_STATUS:         peek = buffer_status;
      REG_EP_ABORT_DONE:       peek = ALL_ONES;
      REG_EP_STALL_ARM:        peek = stall_arm;
      REG_NAK_POLL:            peek = nak_poll_reg;
      REG_EP_STALL_NAK:        peek = stall_nak_status;
      REG_MUXING:              peek = muxing_reg;
      REG_PWR:                 peek = power_reg;
      REG_INTR:                peek = live_intr(serial_status, buffer_status,
                                                stall_nak_status, frame_pending);
      REG_INTE:                peek = irq_enable;
      REG_INTF:                peek = irq_force;
      REG_INTS:                peek = (live_intr(serial_status, buffer_status,
                                                 stall_nak_status, frame_pending)
                                       | irq_force) & irq_enable;
      default:                 peek = '0;
    endcase
  end

  always_comb begin
    address_endpoint_next = address_endpoint;
    main_control_next     = main_control;
    frame_number_next     = frame_number;
    serial_control_next   = serial_control;
    serial_status_next    = serial_status;
    buffer_status_next    = buffer_status;
    stall_arm_next        = stall_arm;
    nak_poll_reg_next     = nak_poll_reg;
    stall_nak_status_next = stall_nak_status;
    muxing_reg_next       = muxing_reg;
    power_reg_next        = power_reg;
    irq_enable_next       = irq_enable;
    irq_force_next        = irq_force;
    frame_pending_next    = frame_pending;
    rdata_next            = '0;

    unique case (req_type)
      REQ_READ: begin
        rdata_next = (peek & mask) >> shift;
        if (reg_addr == REG_SOF_RD) begin
          frame_pending_next = 1'b0;
        end
      end
      REQ_WRITE: begin
        unique case (reg_addr)
          REG_SIE_STATUS:
            serial_status_next = wr_value(op, serial_status, lane, mask, 1'b1);
          REG_BUFF_STATUS:
            buffer_status_next = wr_value(op, buffer_status, lane, mask, 1'b1);
          REG_EP_STALL_NAK:
            stall_nak_status_next = wr_value(op, stall_nak_status, lane, mask, 1'b1);
          REG_ADDR_ENDP:
            address_endpoint_next = wr_value(op, address_endpoint, lane, mask, 1'b0);
          REG_MAIN_CTRL:
            main_control_next = wr_value(op, main_control, lane, mask, 1'b0);
          REG_SOF_WR:
            frame_number_next = wr_value(op, frame_number, lane, mask, 1'b0);
          REG_SIE_CTRL:
            serial_control_next = wr_value(op, serial_control, lane, mask, 1'b0);
          REG_EP_STALL_ARM:
            stall_arm_next = wr_value(op, stall_arm, lane, mask, 1'b0);
          REG_NAK_POLL:
            nak_poll_reg_next = wr_value(op, nak_poll_reg, lane, mask, 1'b0);
          REG_MUXING:
            muxing_reg_next = wr_value(op, muxing_reg, lane, mask, 1'b0);
          REG_PWR:
            power_reg_next = wr_value(op, power_reg, lane, mask, 1'b0);
          REG_INTE:
            irq_enable_next = wr_value(op, irq_enable, lane, mask, 1'b0);
          REG_INTF:
            irq_force_next = wr_value(op, irq_force, lane, mask, 1'b0);
          default: ;
        endcase
      end
      REQ_SET_BUFF: begin
        buffer_status_next = buffer_status | wdata;
      end
      default: begin
        unique case (event_target)
          TGT_SIE_STATUS:  serial_status_next    = serial_status | wdata;
          TGT_BUFF_STATUS: buffer_status_next    = buffer_status | wdata;
          TGT_STALL_NAK:   stall_nak_status_next = stall_nak_status | wdata;
          default:         frame_pending_next    = 1'b1;
        endcase
      end
    endcase

    irq_next = |((live_intr(serial_status_next, buffer_status_next,
                            stall_nak_status_next, frame_pending_next)
                  | irq_force_next) & irq_enable_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_endpoint <= '0;
      main_control     <= '0;
      frame_number     <= '0;
      serial_control   <= '0;
      serial_status    <= '0;
      buffer_status    <= '0;
      stall_arm        <= '0;
      nak_poll_reg     <= '0;
      stall_nak_status <= '0;
      muxing_reg       <= '0;
      power_reg        <= '0;
      irq_enable       <= '0;
      irq_force        <= '0;
      frame_pending    <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        address_endpoint <= address_endpoint_next;
        main_control     <= main_control_next;
        frame_number     <= frame_number_next;
        serial_control   <= serial_control_next;
        serial_status    <= serial_status_next;
        buffer_status    <= buffer_status_next;
        stall_arm        <= stall_arm_next;
        nak_poll_reg     <= nak_poll_reg_next;
        stall_nak_status <= stall_nak_status_next;
        muxing_reg       <= muxing_reg_next;
        power_reg        <= power_reg_next;
        irq_enable       <= irq_enable_next;
        irq_force        <= irq_force_next;
        frame_pending    <= frame_pending_next;
        out_valid        <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata    <= rdata_next;
      irq_line <= irq_next;
    end
  end

  // writes and events never return data
  assert property (@(posedge clk) disable iff (rst)
    accept && (req_type != REQ_READ) |=> (rdata == '0))
    else $error("nonzero read data on a write or event");

  // any read of SOF_RD acknowledges the frame
  assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_READ) && (reg_addr == REG_SOF_RD) |=> !frame_pending)
    else $error("SOF read did not clear frame pending");

  // start of frame event raises the pending flag
  assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_SET_STAT) && (event_target == TGT_SOF) |=> frame_pending)
    else $error("SOF event did not set frame pending");

  // the reported irq matches the state just written
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (irq_line == |((live_intr(serial_status, buffer_status, stall_nak_status,
                                          frame_pending) | irq_force) & irq_enable)))
    else $error("irq_line disagrees with register state");

endmodule
